// ===== rtl/core/hpb_pkg.sv =====
// Shared types and constants for the histogram peak baseline block.
`timescale 1ns / 1ps
`default_nettype none
package hpb_pkg;
    localparam int MAX_ADC_BITS_DEF = 16;
    localparam int COUNT_BITS_DEF = 32;
    localparam int NOISE_LIMIT = 500;
    localparam int MIN_ADC_BITS = 10;
    localparam logic [0:0] REG_ADC_BITS = 1'b0;
    localparam logic [0:0] REG_NOISE_WINDOW = 1'b1;

    typedef struct packed {
        logic [15:0] sample;
        logic        last;
    } t_in;

    typedef struct packed {
        logic [15:0] baseline;
        logic [15:0] peak_bin;
        logic        edge_fallback;
    } t_out;
endpackage
`default_nettype wire

// ===== rtl/core/hpb_div.sv =====
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module hpb_div
    import hpb_pkg::*;
#(
    parameter int NUM_BITS = 64,
    parameter int DEN_BITS = 48
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [NUM_BITS-1:0] i_num,
    input  wire logic [DEN_BITS-1:0] i_den,
    output logic                     o_done,
    output logic [NUM_BITS-1:0]      o_quot
);
    localparam int CW = $clog2(NUM_BITS + 1);
    logic [NUM_BITS-1:0] r_q, n_q;
    logic [DEN_BITS:0]   r_rem, n_rem;
    logic [DEN_BITS-1:0] r_den;
    logic [CW-1:0]       r_cnt;
    logic                r_busy, r_done;
    logic [DEN_BITS:0]   w_sh;

    always_comb begin
        w_sh = {r_rem[DEN_BITS-1:0], r_q[NUM_BITS-1]};
        n_q = {r_q[NUM_BITS-2:0], 1'b0};
        n_rem = w_sh;
        if (w_sh >= {1'b0, r_den}) begin
            n_rem = w_sh - {1'b0, r_den};
            n_q[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= CW'(NUM_BITS);
                r_q <= i_num;
                r_rem <= '0;
                r_den <= i_den;
            end else if (r_busy) begin
                r_q <= n_q;
                r_rem <= n_rem;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
    assign o_done = r_done;
    assign o_quot = r_q;
endmodule
`default_nettype wire

// ===== rtl/core/histogram_peak_baseline_core.sv =====
// Top level of the histogram peak baseline block.
// A sample without the last mark passes through read, compare and increment, and write.
// A sample with the last mark adds scans of the histogram memory, one bin per cycle: the peak
// search between the noise windows, the edge maxima when no peak is found and the window for
// the mean; then the division and a pass that clears the memory; the single port sets these.
// After reset a clearing pass over all 2^MAX_ADC_BITS bins runs before any sample is taken.
`timescale 1ns / 1ps
`default_nettype none
module histogram_peak_baseline_core
    import hpb_pkg::*;
#(
    parameter int MAX_ADC_BITS = MAX_ADC_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire t_in         i_data,
    output logic             o_valid,
    input  wire logic        i_stall,
    output t_out             o_data,
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [8:0]  i_cfg_data
);
    localparam int DEPTH = 1 << MAX_ADC_BITS;
    localparam int AW = MAX_ADC_BITS;
    localparam int BW = MAX_ADC_BITS + 1;
    localparam int SW = COUNT_BITS + MAX_ADC_BITS;
    localparam int SUMW = SW + $clog2(2 * NOISE_LIMIT);
    localparam int NW = 64;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RD, S_WR, S_PK, S_UP, S_LO, S_SUM, S_DIV, S_OUT
    } t_state;

    t_state r_state;
    logic [COUNT_BITS-1:0] r_mem [DEPTH];
    logic [COUNT_BITS-1:0] r_rd;
    logic [AW-1:0]  r_addr;
    logic [4:0]     r_adc_bits;
    logic [8:0]     r_nw_reg;
    logic           r_last;
    logic [BW-1:0]  r_b, r_end, r_best, r_size, r_nw, r_peak;
    logic [COUNT_BITS-1:0] r_bmax, r_upmax;
    logic           r_pipe, r_pipe2, r_edge;
    logic [SUMW-1:0] r_sum;
    logic [SW-1:0]  r_cnt;
    logic           r_ov;
    t_out           r_out;
    logic           w_start, w_done;
    logic [NW-1:0]  w_quot;
    logic [4:0]     w_bits;
    logic [BW-1:0]  w_size, w_nw;
    logic [BW-1:0]  r_pb, r_pb2;

    always_comb begin
        w_bits = r_adc_bits;
        if (r_adc_bits < 5'(MIN_ADC_BITS)) w_bits = 5'(MIN_ADC_BITS);
        if (r_adc_bits > 5'(MAX_ADC_BITS)) w_bits = 5'(MAX_ADC_BITS);
        w_size = BW'(1) << w_bits;
        w_nw = (r_nw_reg > 9'(NOISE_LIMIT)) ? BW'(NOISE_LIMIT) : BW'(r_nw_reg);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adc_bits <= 5'd14;
            r_nw_reg <= 9'd10;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_ADC_BITS:     r_adc_bits <= i_cfg_data[4:0];
                REG_NOISE_WINDOW: r_nw_reg <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The memory read is registered; r_pb and r_pb2 carry the bin of the read in flight.
    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[r_addr];
    end

    assign w_start = (r_state == S_SUM) && (r_b >= r_end) && !r_pipe && !r_pipe2
                     && (r_cnt != '0);

    hpb_div #(.NUM_BITS(NW), .DEN_BITS(SW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start),
        .i_num(NW'(r_sum)), .i_den(r_cnt), .o_done(w_done), .o_quot(w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_addr <= '0;
            r_pipe <= 1'b0;
            r_pipe2 <= 1'b0;
        end else begin
            r_pipe <= 1'b0;
            r_pipe2 <= r_pipe;
            r_pb2 <= r_pb;
            unique case (r_state)
                S_CLEAR: begin
                    r_mem[r_addr] <= '0;
                    r_addr <= r_addr + 1'b1;
                    if (r_addr == AW'(DEPTH - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_size <= w_size;
                        r_nw <= w_nw;
                        r_last <= i_data.last;
                        if (BW'(i_data.sample) >= w_size) r_addr <= AW'(w_size - 1'b1);
                        else r_addr <= AW'(i_data.sample);
                        r_state <= S_RD;
                    end
                end
                S_RD: r_state <= S_WR;
                S_WR: begin
                    if (r_rd != {COUNT_BITS{1'b1}}) r_mem[r_addr] <= r_rd + 1'b1;
                    if (r_last) begin
                        r_b <= r_nw;
                        r_end <= r_size - r_nw;
                        r_best <= r_nw;
                        r_bmax <= '0;
                        r_addr <= AW'(r_nw);
                        r_state <= S_PK;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                default: scan_step();
            endcase
        end
    end

    // Shared scan engine: one address issued per cycle, one count compared or summed per cycle.
    task automatic scan_step();
        logic [BW-1:0] nb;
        logic [SW-1:0] prod;
        nb = r_b + 1'b1;
        prod = SW'(r_pb2) * SW'(r_rd);
        unique case (r_state)
            S_PK, S_UP, S_LO: begin
                if (r_pipe2 && (r_rd > r_bmax)) begin
                    r_bmax <= r_rd;
                    r_best <= r_pb2;
                end
                if (r_b < r_end) begin
                    r_pb <= r_b;
                    r_addr <= AW'(r_b);
                    r_b <= nb;
                    r_pipe <= 1'b1;
                end else if (!r_pipe && !r_pipe2) begin
                    if (r_state == S_PK) begin
                        r_peak <= r_best;
                        if (r_bmax != '0) begin
                            r_edge <= 1'b0;
                            r_b <= r_best - r_nw;
                            r_end <= (r_best + r_nw > r_size) ? r_size : r_best + r_nw;
                            r_sum <= '0; r_cnt <= '0;
                            r_state <= S_SUM;
                        end else begin
                            r_edge <= 1'b1;
                            r_b <= r_size - r_nw; r_end <= r_size;
                            r_bmax <= '0;
                            r_state <= S_UP;
                        end
                    end else if (r_state == S_UP) begin
                        r_upmax <= r_bmax;
                        r_bmax <= '0;
                        r_b <= '0; r_end <= r_nw;
                        r_state <= S_LO;
                    end else begin
                        if (r_upmax > r_bmax) begin
                            r_b <= r_size - r_nw; r_end <= r_size;
                        end else begin
                            r_b <= '0; r_end <= r_nw;
                        end
                        r_sum <= '0; r_cnt <= '0;
                        r_state <= S_SUM;
                    end
                end
            end
            S_SUM: begin
                if (r_pipe2) begin
                    r_sum <= r_sum + SUMW'(prod);
                    r_cnt <= r_cnt + SW'(r_rd);
                end
                if (r_b < r_end) begin
                    r_pb <= r_b;
                    r_addr <= AW'(r_b);
                    r_b <= nb;
                    r_pipe <= 1'b1;
                end else if (!r_pipe && !r_pipe2) begin
                    r_ov <= 1'b0;
                    if (r_cnt == '0) begin
                        r_out.baseline <= '0;
                        r_addr <= '0;
                        r_state <= S_OUT;
                        r_ov <= 1'b1;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (w_done) begin
                    r_out.baseline <= w_quot[15:0];
                    r_addr <= '0;
                    r_ov <= 1'b1;
                    r_state <= S_OUT;
                end
            end
            S_OUT: begin
                r_out.peak_bin <= 16'(r_peak);
                r_out.edge_fallback <= r_edge;
                if (r_ov) begin
                    r_mem[r_addr] <= '0;
                    r_addr <= r_addr + 1'b1;
                    if (r_addr == AW'(DEPTH - 1)) r_ov <= 1'b0;
                end else if (!i_stall) begin
                    r_state <= S_IDLE;
                end
            end
            default: r_state <= S_IDLE;
        endcase
    endtask

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT) && !r_ov;
    assign o_data = r_out;

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && !o_stall)) else $error("output and input active together");
    a_rd_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |=> (r_state == S_WR)) else $error("increment skipped");
    a_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |-> (r_cnt != '0)) else $error("divide by zero");
endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for the histogram peak baseline core, with a predictor and random traffic.
`timescale 1ns / 1ps
module testbench;
    import hpb_pkg::*;

    localparam int DEPTH = 1 << 16;
    localparam int WATCHDOG_LIMIT = 1500000;

    typedef struct {
        logic [15:0] sample;
        logic        last;
        bit          typed;
        t_out        want;
    } t_row;

    typedef struct {
        int adc;
        int nw;
        int items;
    } t_phase;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    t_in        i_data = '0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    t_out       o_data;
    logic       i_cfg_we = 1'b0;
    logic [0:0] i_cfg_index = REG_ADC_BITS;
    logic [8:0] i_cfg_data = '0;

    int unsigned bin_count [DEPTH];
    int          touched_bins [$];
    int          cfg_adc = 14;
    int          cfg_nw = 10;
    t_out        baseline_queue [$];
    bit          failed = 1'b0;
    int          idle_cycles = 0;
    int          stall_left = 0;
    bit          calm_rx = 1'b0;

    histogram_peak_baseline_core dut (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int hist_bins();
        int b;
        b = cfg_adc < MIN_ADC_BITS ? MIN_ADC_BITS : cfg_adc;
        b = b > 16 ? 16 : b;
        return 1 << b;
    endfunction

    function automatic int first_peak(int lo, int hi);
        int best;
        best = lo;
        for (int b = lo; b < hi; b++) begin
            if (bin_count[b] > bin_count[best]) best = b;
        end
        return best;
    endfunction

    function automatic longint unsigned window_max(int lo, int hi);
        if (lo >= hi) return 0;
        return bin_count[first_peak(lo, hi)];
    endfunction

    // Counts one sample; returns 1 with the baseline result when the sample closes a set.
    function automatic bit count_sample(logic [15:0] sample, logic last, output t_out res);
        int size, nw, s, peak, lo, hi;
        longint unsigned sum, cnt;
        bit fallback;
        size = hist_bins();
        nw = cfg_nw > NOISE_LIMIT ? NOISE_LIMIT : cfg_nw;
        s = sample;
        if (s >= size) s = size - 1;
        if (bin_count[s] != 32'hFFFF_FFFF) bin_count[s]++;
        touched_bins.push_back(s);
        res = '0;
        if (!last) return 1'b0;
        fallback = 1'b0;
        peak = first_peak(nw, size - nw);
        if (bin_count[peak] != 0) begin
            lo = peak - nw;
            hi = peak + nw > size ? size : peak + nw;
        end else begin
            fallback = 1'b1;
            if (window_max(size - nw, size) > window_max(0, nw)) begin
                lo = size - nw;
                hi = size;
            end else begin
                lo = 0;
                hi = nw;
            end
        end
        sum = 0;
        cnt = 0;
        for (int b = lo; b < hi; b++) begin
            sum += longint'(b) * bin_count[b];
            cnt += bin_count[b];
        end
        res.baseline = cnt > 0 ? 16'(sum / cnt) : 16'd0;
        res.peak_bin = 16'(peak);
        res.edge_fallback = fallback;
        foreach (touched_bins[i]) bin_count[touched_bins[i]] = 0;
        touched_bins.delete();
        return 1'b1;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send(logic [15:0] sample, logic last, bit typed, t_out want);
        int gap;
        t_out res;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= '{sample: sample, last: last};
        do @(posedge i_clk); while (o_stall);
        if (count_sample(sample, last, res)) baseline_queue.push_back(typed ? want : res);
    endtask

    // Lets the core finish a set, including its clearing pass, before registers change.
    task automatic drain();
        @(posedge i_clk);
        i_valid <= 1'b0;
        while (baseline_queue.size() != 0) @(posedge i_clk);
        repeat (2 * DEPTH + 600) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [0:0] index, logic [8:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (index == REG_ADC_BITS) cfg_adc = value[4:0];
        else cfg_nw = value;
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (baseline_queue.size() == 0) begin
                $display("%0t: unexpected transaction baseline=%0d peak=%0d edge=%0d",
                         $time, o_data.baseline, o_data.peak_bin, o_data.edge_fallback);
                failed = 1'b1;
            end else begin
                if (o_data.baseline !== baseline_queue[0].baseline) begin
                    $display("%0t: baseline expected %0d actual %0d",
                             $time, baseline_queue[0].baseline, o_data.baseline);
                    failed = 1'b1;
                end
                if (o_data.peak_bin !== baseline_queue[0].peak_bin) begin
                    $display("%0t: peak_bin expected %0d actual %0d",
                             $time, baseline_queue[0].peak_bin, o_data.peak_bin);
                    failed = 1'b1;
                end
                if (o_data.edge_fallback !== baseline_queue[0].edge_fallback) begin
                    $display("%0t: edge_fallback expected %0d actual %0d",
                             $time, baseline_queue[0].edge_fallback, o_data.edge_fallback);
                    failed = 1'b1;
                end
                void'(baseline_queue.pop_front());
            end
        end
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall <= 1'b1;
        end else if ($urandom_range(0, 199) == 0) begin
            calm_rx <= ~calm_rx;
            i_stall <= 1'b0;
        end else if (!calm_rx && $urandom_range(0, 99) < 30) begin
            stall_left <= $urandom_range(0, 99) < 90 ? $urandom_range(0, 3)
                                                     : $urandom_range(20, 80);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    initial begin
        t_row   rows [$];
        t_phase phases [$];
        t_out   none;
        int     size, left, set_len, center, spread, v;
        bit     at_edges;
        none = '0;
        rows = '{
            '{16'd0, 1'b1, 1'b1, '{16'd0, 16'd10, 1'b1}},
            '{16'hFFFF, 1'b1, 1'b1, '{16'd16383, 16'd10, 1'b1}},
            '{16'd100, 1'b0, 1'b0, none},
            '{16'd100, 1'b0, 1'b0, none},
            '{16'd100, 1'b1, 1'b1, '{16'd100, 16'd100, 1'b0}},
            '{16'd16373, 1'b0, 1'b0, none},
            '{16'd16374, 1'b0, 1'b0, none},
            '{16'd9, 1'b0, 1'b0, none},
            '{16'd10, 1'b1, 1'b0, none},
            '{16'h5555, 1'b0, 1'b0, none},
            '{16'h2AAA, 1'b0, 1'b0, none},
            '{16'd200, 1'b0, 1'b0, none},
            '{16'd205, 1'b1, 1'b0, none}
        };
        phases = '{
            '{10, 10, 150}, '{0, 0, 40}, '{10, 511, 60}, '{12, 3, 60},
            '{10, 1, 110}, '{16, 37, 20}, '{31, 500, 15}, '{11, 250, 80}
        };
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (rows[i]) send(rows[i].sample, rows[i].last, rows[i].typed, rows[i].want);
        drain();

        // A resolution change in the middle of a set keeps the counts already taken.
        send(16'd5000, 1'b0, 1'b0, none);
        send(16'd700, 1'b0, 1'b0, none);
        @(posedge i_clk);
        i_valid <= 1'b0;
        repeat (20) @(posedge i_clk);
        write_reg(REG_ADC_BITS, 9'd10);
        send(16'd3, 1'b1, 1'b0, none);
        drain();

        foreach (phases[p]) begin
            write_reg(REG_ADC_BITS, 9'(phases[p].adc));
            write_reg(REG_NOISE_WINDOW, 9'(phases[p].nw));
            size = hist_bins();
            left = phases[p].items;
            while (left > 0) begin
                set_len = size >= (1 << 15) ? left : $urandom_range(1, 20);
                if (set_len > left) set_len = left;
                left -= set_len;
                center = $urandom_range(0, size - 1);
                spread = $urandom_range(0, 99) < 50 ? $urandom_range(0, 8)
                                                    : $urandom_range(0, 600);
                at_edges = $urandom_range(0, 99) < 20;
                for (int k = 0; k < set_len; k++) begin
                    if ($urandom_range(0, 99) < 15) begin
                        v = $urandom_range(0, 65535);
                    end else if (at_edges) begin
                        v = $urandom_range(0, 1) ? $urandom_range(0, 40)
                                                 : size - 1 - $urandom_range(0, 40);
                    end else begin
                        v = center + $urandom_range(0, 2 * spread) - spread;
                        if (v < 0) v = 0;
                    end
                    send(16'(v), k == set_len - 1, 1'b0, none);
                end
            end
            drain();
        end

        if (!failed && baseline_queue.size() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end
endmodule
